>>> src/ipc_pkg.sv
// Shared types and constants for the irrigation pump controller.
// Used by the register bank, the controller core, the result register and the top level.
package ipc_pkg;

  // Default counter width for the millisecond counters
  localparam int unsigned COUNT_WIDTH_DEFAULT = 24;

  // Field and register widths
  localparam int unsigned MOIST_W   = 7;
  localparam int unsigned CMD_W     = 8;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned CFG_IDX_W = 8;

  // Reset values of the configuration registers
  localparam logic [MOIST_W-1:0] THRESHOLD_RESET = 7'd40;
  localparam logic [TIME_W-1:0]  WATERING_RESET  = 24'd5000;
  localparam logic [TIME_W-1:0]  COOLDOWN_RESET  = 24'd10000;
  localparam logic [TIME_W-1:0]  INTERVAL_RESET  = 24'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATERING  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 8'd3;

  // Item kinds
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  // Master command codes
  localparam logic [CMD_W-1:0] CMD_OFF  = 8'h00;
  localparam logic [CMD_W-1:0] CMD_ON   = 8'h01;
  localparam logic [CMD_W-1:0] CMD_AUTO = 8'h02;

  // Current configuration as seen by the core
  typedef struct packed {
    logic [MOIST_W-1:0] moisture_threshold;
    logic [TIME_W-1:0]  watering_ms;
    logic [TIME_W-1:0]  cooldown_ms;
    logic [TIME_W-1:0]  read_interval_ms;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic               pump_on;
    logic               manual_mode;
    logic               report_valid;
    logic [MOIST_W-1:0] report_moisture;
    logic               report_pump;
  } result_t;

endpackage

>>> src/ipc_cfg_regs.sv
// Configuration register bank for the irrigation pump controller.
// Depends on ipc_pkg for register indexes, widths and reset values.
module ipc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipc_pkg::TIME_W-1:0]    cfg_data,
  output ipc_pkg::cfg_t             cfg
);
  import ipc_pkg::*;

  cfg_t regs;

  // Take a write word in every cycle
  assign cfg_ready = 1'b1;
  assign cfg      = regs;

  // Write the addressed register; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.moisture_threshold <= THRESHOLD_RESET;
      regs.watering_ms        <= WATERING_RESET;
      regs.cooldown_ms        <= COOLDOWN_RESET;
      regs.read_interval_ms   <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: regs.moisture_threshold <= cfg_data[MOIST_W-1:0];
        REG_WATERING:  regs.watering_ms        <= cfg_data;
        REG_COOLDOWN:  regs.cooldown_ms        <= cfg_data;
        REG_INTERVAL:  regs.read_interval_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/ipc_core.sv
// Controller core: mode, watering, cooldown and read counters, updated once per word.
// Depends on ipc_pkg for command codes, the configuration struct and the result struct.
module ipc_core #(
  parameter int unsigned COUNT_WIDTH = ipc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        func,
  input  logic [ipc_pkg::CMD_W-1:0]   command_code,
  input  logic [ipc_pkg::MOIST_W-1:0] moisture_percent,
  input  ipc_pkg::cfg_t               cfg,
  output ipc_pkg::result_t            result
);
  import ipc_pkg::*;

  localparam logic [32:0] CNT_MAX33 = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  // Clamp a configured time to the counter range
  function automatic logic [COUNT_WIDTH-1:0] clamp_cnt(input logic [TIME_W-1:0] v);
    logic [32:0] ext;
    ext = {{(33-TIME_W){1'b0}}, v};
    return (ext > CNT_MAX33) ? CNT_MAX33[COUNT_WIDTH-1:0] : ext[COUNT_WIDTH-1:0];
  endfunction

  // Saturating increment
  function automatic logic [COUNT_WIDTH-1:0] inc_sat(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + CNT_ONE;
  endfunction

  logic                   manual_flag, manual_flag_next;
  logic                   manual_pump, manual_pump_next;
  logic                   watering_flag, watering_flag_next;
  logic [COUNT_WIDTH-1:0] watering_elapsed, watering_elapsed_next;
  logic [COUNT_WIDTH-1:0] cooldown_left, cooldown_left_next;
  logic [COUNT_WIDTH-1:0] since_read, since_read_next;
  logic [MOIST_W-1:0]     report_moisture_reg, report_moisture_reg_next;
  logic                   report_pump_reg, report_pump_reg_next;
  logic                   refreshed;
  logic [COUNT_WIDTH-1:0] interval_c, watering_c, cooldown_c;

  assign interval_c = clamp_cnt(cfg.read_interval_ms);
  assign watering_c = clamp_cnt(cfg.watering_ms);
  assign cooldown_c = clamp_cnt(cfg.cooldown_ms);

  // Work out the next state for the current word
  always_comb begin
    manual_flag_next         = manual_flag;
    manual_pump_next         = manual_pump;
    watering_flag_next       = watering_flag;
    watering_elapsed_next    = watering_elapsed;
    cooldown_left_next       = cooldown_left;
    since_read_next          = since_read;
    report_moisture_reg_next = report_moisture_reg;
    report_pump_reg_next     = report_pump_reg;
    refreshed                = 1'b0;

    if (func == FUNC_COMMAND) begin
      if (command_code == CMD_AUTO) begin
        // Leaving manual mode drops any watering and cooldown
        if (manual_flag) begin
          watering_flag_next = 1'b0;
          cooldown_left_next = '0;
        end
        manual_flag_next = 1'b0;
      end else if (command_code == CMD_ON || command_code == CMD_OFF) begin
        manual_flag_next = 1'b1;
        manual_pump_next = (command_code == CMD_ON);
      end
    end else begin
      // Advance the counters by one millisecond
      if (cooldown_left != '0) cooldown_left_next = cooldown_left - CNT_ONE;
      if (watering_flag) watering_elapsed_next = inc_sat(watering_elapsed);
      since_read_next = inc_sat(since_read);

      // Evaluate moisture and publish a report
      if (since_read_next >= interval_c) begin
        since_read_next = '0;
        if (!manual_flag && !watering_flag &&
            moisture_percent < cfg.moisture_threshold &&
            cooldown_left_next == '0) begin
          watering_flag_next    = 1'b1;
          watering_elapsed_next = '0;
        end
        report_moisture_reg_next = moisture_percent;
        report_pump_reg_next     = manual_flag ? manual_pump : watering_flag_next;
        refreshed                = 1'b1;
      end

      // End the watering and load the cooldown; this report wins
      if (!manual_flag && watering_flag_next && watering_elapsed_next >= watering_c) begin
        watering_flag_next       = 1'b0;
        cooldown_left_next       = cooldown_c;
        report_moisture_reg_next = moisture_percent;
        report_pump_reg_next     = 1'b0;
        refreshed                = 1'b1;
      end
    end

    result.pump_on         = manual_flag_next ? manual_pump_next : watering_flag_next;
    result.manual_mode     = manual_flag_next;
    result.report_valid    = refreshed;
    result.report_moisture = report_moisture_reg_next;
    result.report_pump     = report_pump_reg_next;
  end

  // Hold state; advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      manual_flag         <= 1'b0;
      manual_pump         <= 1'b0;
      watering_flag       <= 1'b0;
      watering_elapsed    <= '0;
      cooldown_left       <= '0;
      since_read          <= '0;
      report_moisture_reg <= '0;
      report_pump_reg     <= 1'b0;
    end else if (step) begin
      manual_flag         <= manual_flag_next;
      manual_pump         <= manual_pump_next;
      watering_flag       <= watering_flag_next;
      watering_elapsed    <= watering_elapsed_next;
      cooldown_left       <= cooldown_left_next;
      since_read          <= since_read_next;
      report_moisture_reg <= report_moisture_reg_next;
      report_pump_reg     <= report_pump_reg_next;
    end
  end

endmodule

>>> src/ipc_out_reg.sv
// Result register with valid and ready for the irrigation pump controller.
// Depends on ipc_pkg for the result struct.
module ipc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ipc_pkg::result_t result_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output ipc_pkg::result_t result_out
);
  import ipc_pkg::*;

  result_t data;

  // Free when empty or when the held word leaves this cycle
  assign can_load   = !out_valid || out_ready;
  assign result_out = data;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (load) data <= result_in;
  end

endmodule

>>> src/irrigation_pump_controller.sv
// Irrigation pump controller. Each input word is a one millisecond tick carrying the
// moisture percent, or a master command; each produces exactly one result word. The block
// takes one word per cycle: the core updates its counters in the cycle of acceptance and
// the result lands in a single output register, so a new word is taken whenever that
// register is empty or is being emptied in the same cycle.
// Configuration writes are taken every cycle; indexes beyond the list are dropped.
module irrigation_pump_controller #(
  parameter int unsigned COUNT_WIDTH = ipc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [ipc_pkg::CMD_W-1:0]     command_code,
  input  logic [ipc_pkg::MOIST_W-1:0]   moisture_percent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          pump_on,
  output logic                          manual_mode,
  output logic                          report_valid,
  output logic [ipc_pkg::MOIST_W-1:0]   report_moisture,
  output logic                          report_pump,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipc_pkg::TIME_W-1:0]    cfg_data
);
  import ipc_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  result_t held;
  logic    step;

  assign step = in_valid && in_ready;

  ipc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .func             (func),
    .command_code     (command_code),
    .moisture_percent (moisture_percent),
    .cfg              (cfg),
    .result           (core_result)
  );

  ipc_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .result_in  (core_result),
    .can_load   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (held)
  );

  // Unpack the result word onto the ports
  assign pump_on         = held.pump_on;
  assign manual_mode     = held.manual_mode;
  assign report_valid    = held.report_valid;
  assign report_moisture = held.report_moisture;
  assign report_pump     = held.report_pump;

endmodule

>>> tb/irrigation_pump_controller_tb.sv
// Testbench for the irrigation pump controller: directed and random tick and command words,
// checked word by word against a predictor of the controller kept in this file.
// Depends on ipc_pkg and the irrigation_pump_controller top level.
module irrigation_pump_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipc_pkg::*;

  localparam int unsigned CNT_W      = COUNT_WIDTH_DEFAULT;
  localparam logic [31:0] CNT_MAX    = 32'((64'd1 << CNT_W) - 64'd1);
  localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_WORDS = 125;

  bit clk;
  logic                 rst              = 1'b1;
  logic                 in_valid         = 1'b0;
  logic                 func             = FUNC_TICK;
  logic [CMD_W-1:0]     command_code     = '0;
  logic [MOIST_W-1:0]   moisture_percent = '0;
  logic                 out_ready        = 1'b0;
  logic                 cfg_valid        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index        = '0;
  logic [TIME_W-1:0]    cfg_data         = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 pump_on;
  logic                 manual_mode;
  logic                 report_valid;
  logic [MOIST_W-1:0]   report_moisture;
  logic                 report_pump;
  logic                 cfg_ready;

  // Predicted controller state and configuration
  logic [MOIST_W-1:0] thr_cfg;
  logic [TIME_W-1:0]  water_cfg;
  logic [TIME_W-1:0]  cool_cfg;
  logic [TIME_W-1:0]  interval_cfg;
  logic               mode_manual;
  logic               relay_manual;
  logic               watering;
  logic [31:0]        water_elapsed;
  logic [31:0]        cool_left;
  logic [31:0]        ticks_since_read;
  logic [MOIST_W-1:0] rpt_moist;
  logic               rpt_pump;

  result_t pending_status[$];

  bit no_stall = 1'b0;
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int reports_seen = 0;
  int waterings_started = 0;
  int settings_used = 0;

  irrigation_pump_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .command_code(command_code), .moisture_percent(moisture_percent),
    .out_valid(out_valid), .out_ready(out_ready),
    .pump_on(pump_on), .manual_mode(manual_mode), .report_valid(report_valid),
    .report_moisture(report_moisture), .report_pump(report_pump),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a run that hangs
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] clamp_time(input logic [TIME_W-1:0] v);
    return (32'(v) > CNT_MAX) ? CNT_MAX : 32'(v);
  endfunction

  function automatic logic [31:0] bump_sat(input logic [31:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 32'd1;
  endfunction

  // Advance the predicted state by one word and queue the status it must produce
  task automatic advance_pump_model(input logic f, input logic [CMD_W-1:0] cmd,
                                    input logic [MOIST_W-1:0] moist);
    result_t r;
    logic fresh;
    fresh = 1'b0;
    if (f == FUNC_COMMAND) begin
      if (cmd == CMD_AUTO) begin
        // leaving manual mode drops any watering and cooldown
        if (mode_manual) begin
          watering  = 1'b0;
          cool_left = '0;
        end
        mode_manual = 1'b0;
      end else if (cmd == CMD_ON || cmd == CMD_OFF) begin
        mode_manual  = 1'b1;
        relay_manual = (cmd == CMD_ON);
      end
    end else begin
      if (cool_left != 0) cool_left = cool_left - 32'd1;
      if (watering) water_elapsed = bump_sat(water_elapsed);
      ticks_since_read = bump_sat(ticks_since_read);
      // periodic read: maybe start watering, refresh the report
      if (ticks_since_read >= clamp_time(interval_cfg)) begin
        ticks_since_read = '0;
        if (!mode_manual && !watering && moist < thr_cfg && cool_left == 0) begin
          watering      = 1'b1;
          water_elapsed = '0;
          waterings_started++;
        end
        rpt_moist = moist;
        rpt_pump  = mode_manual ? relay_manual : watering;
        fresh     = 1'b1;
      end
      // watering end wins over the read report
      if (!mode_manual && watering && water_elapsed >= clamp_time(water_cfg)) begin
        watering  = 1'b0;
        cool_left = clamp_time(cool_cfg);
        rpt_moist = moist;
        rpt_pump  = 1'b0;
        fresh     = 1'b1;
      end
    end
    r.pump_on         = mode_manual ? relay_manual : watering;
    r.manual_mode     = mode_manual;
    r.report_valid    = fresh;
    r.report_moisture = rpt_moist;
    r.report_pump     = rpt_pump;
    pending_status.push_back(r);
  endtask

  // Present one word, idling at random first, and predict it once taken
  task automatic send_word(input logic f, input logic [CMD_W-1:0] cmd,
                           input logic [MOIST_W-1:0] moist);
    @(negedge clk);
    if (!no_stall) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid         <= 1'b1;
    func             <= f;
    command_code     <= cmd;
    moisture_percent <= moist;
    do @(posedge clk); while (!in_ready);
    advance_pump_model(f, cmd, moist);
    words_sent++;
  endtask

  task automatic send_tick(input logic [MOIST_W-1:0] moist);
    send_word(FUNC_TICK, CMD_W'($urandom), moist);
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd);
    send_word(FUNC_COMMAND, cmd, MOIST_W'($urandom));
  endtask

  // Hold the input and wait until every queued status has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD: thr_cfg = d[MOIST_W-1:0];
      REG_WATERING:  water_cfg = d;
      REG_COOLDOWN:  cool_cfg = d;
      REG_INTERVAL:  interval_cfg = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [TIME_W-1:0] thr, input logic [TIME_W-1:0] water,
                             input logic [TIME_W-1:0] cool, input logic [TIME_W-1:0] interval);
    settle();
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_WATERING, water);
    cfg_write(REG_COOLDOWN, cool);
    cfg_write(REG_INTERVAL, interval);
    settings_used++;
  endtask

  // Compare each returned status word with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    logic bad;
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (report_valid) reports_seen++;
      if (pending_status.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: status word with nothing pending", $realtime);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        bad = (pump_on !== want.pump_on) || (manual_mode !== want.manual_mode) ||
              (report_valid !== want.report_valid) ||
              (report_moisture !== want.report_moisture) ||
              (report_pump !== want.report_pump);
        if (bad) begin
          if (mismatches < 10)
            $display("%0t: pump/manual/rv/moist/rpump exp %b %b %b %0d %b got %b %b %b %0d %b",
                     $realtime, want.pump_on, want.manual_mode, want.report_valid,
                     want.report_moisture, want.report_pump, pump_on, manual_mode,
                     report_valid, report_moisture, report_pump);
          mismatches++;
        end
      end
    end
  end

  // Drive the result side ready with random stalls
  always @(negedge clk) begin
    out_ready <= no_stall || ($urandom_range(99) >= 22);
  end

  // Full auto cycle: read, start, run, end report, cooldown
  task automatic test_auto_cycle();
    load_config(40, 2, 3, 2);
    send_tick(100);
    send_tick(39);
    send_tick(127);
    send_tick(0);
    send_tick(0);
    send_tick(0);
    send_tick(0);
    send_tick(40);
    send_tick(0);
    send_tick(0);
  endtask

  // Zero watering time and zero read interval
  task automatic test_zero_times();
    load_config(100, 0, 0, 0);
    send_tick(99);
    send_tick(99);
    send_tick(127);
    send_tick(0);
  endtask

  // Manual on and off, auto from manual and from auto, unknown codes
  task automatic test_commands();
    load_config(127, 5, 4, 1);
    send_tick(0);
    send_command(CMD_ON);
    send_tick(50);
    send_command(CMD_OFF);
    send_tick(50);
    send_command(CMD_AUTO);
    send_command(CMD_AUTO);
    send_command(8'h03);
    send_command(8'hFF);
    send_command(8'h80);
    send_tick(0);
  endtask

  // Register extremes, stray upper data bits and dropped indexes
  task automatic test_config_extremes();
    load_config(24'hFFFF80, TMAX, TMAX, TMAX);
    settle();
    cfg_write(8'hFF, 24'h5A5A5A);
    cfg_write(8'd4, 24'hA5A5A5);
    send_tick(0);
    send_tick(127);
    load_config(127, 1, 0, 1);
    send_tick(126);
    send_tick(0);
    send_tick(0);
  endtask

  // Random phases with fresh settings, mostly ticks near the threshold
  task automatic test_random();
    logic [TIME_W-1:0] thr, water, cool, interval;
    int m;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(3))
        0: thr = 0;
        1: thr = 127;
        default: thr = TIME_W'($urandom_range(20, 90));
      endcase
      water    = ($urandom_range(9) == 0) ? TMAX : TIME_W'($urandom_range(0, 6));
      cool     = ($urandom_range(9) == 0) ? TMAX : TIME_W'($urandom_range(0, 8));
      interval = ($urandom_range(9) == 0) ? TMAX : TIME_W'($urandom_range(0, 4));
      if (p == 0) begin
        thr = 60; water = 3; cool = 2; interval = 1;
      end else if (p == 2) begin
        thr = 100; water = TMAX; cool = TMAX; interval = 1;
      end
      load_config(thr, water, cool, interval);
      no_stall = (p == 3);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // pause once until the controller has caught up
        if (p == 4 && i == PHASE_WORDS / 2) settle();
        if ($urandom_range(99) < 88) begin
          if ($urandom_range(99) < 70) begin
            m = int'(thr[MOIST_W-1:0]) + $urandom_range(0, 6) - 3;
            if (m < 0) m = 0;
            if (m > 127) m = 127;
          end else begin
            m = $urandom_range(0, 127);
          end
          send_tick(MOIST_W'(m));
        end else if ($urandom_range(99) < 80) begin
          send_command(CMD_W'($urandom_range(0, 2)));
        end else begin
          send_command(CMD_W'($urandom));
        end
      end
      no_stall = 1'b0;
    end
  endtask

  initial begin
    thr_cfg          = THRESHOLD_RESET;
    water_cfg        = WATERING_RESET;
    cool_cfg         = COOLDOWN_RESET;
    interval_cfg     = INTERVAL_RESET;
    mode_manual      = 1'b0;
    relay_manual     = 1'b0;
    watering         = 1'b0;
    water_elapsed    = '0;
    cool_left        = '0;
    ticks_since_read = '0;
    rpt_moist        = '0;
    rpt_pump         = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // two ticks and an auto command at reset settings before any register write
    send_tick(10);
    send_command(CMD_AUTO);
    send_tick(127);
    test_auto_cycle();
    test_zero_times();
    test_commands();
    test_config_extremes();
    test_random();

    settle();
    repeat (10) @(posedge clk);
    if (pending_status.size() != 0) mismatches++;
    $display("Checked %0d of %0d words over %0d settings: %0d reports, %0d waterings started",
             words_checked, words_sent, settings_used, reports_seen, waterings_started);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
